/* rtl/rsce_pkg.sv */
// shared types, constants and gf(256) tables for the ccsds reed-solomon encoder
// field polynomial 0x187, conventional basis; no dependencies
package rsce_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CountWidth   = 6;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   // register index of roots_mode (paddr bit 2 and up)
   localparam logic CSR_ROOTS_MODE = 1'b0;

   localparam logic [CountWidth-1:0] PARITY_T16 = 6'd32;
   localparam logic [CountWidth-1:0] PARITY_T8  = 6'd16;
   localparam logic [CountWidth-1:0] ONE_WORD   = 6'd1;
   localparam logic [ByteWidth-1:0]  MAX_COUNT  = 8'd255;
   localparam logic [ByteWidth-1:0]  NO_LOG     = 8'd255;

   typedef logic [ByteWidth-1:0] byte_type;

   // control broadcast to every parity cell
   typedef struct packed {
      logic     clear;
      logic     shift_en;
      logic     live;
      logic     mode32;
      byte_type fb_log;
   } cell_ctrl_type;

   // load request into the output buffer
   typedef struct packed {
      logic                  valid;
      logic                  error;
      logic [CountWidth-1:0] count;
   } load_ctrl_type;

   localparam byte_type GF_EXP [256] = '{
      8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h87,8'h89,8'h95,8'had,8'hdd,8'h3d,8'h7a,8'hf4,
      8'h6f,8'hde,8'h3b,8'h76,8'hec,8'h5f,8'hbe,8'hfb,8'h71,8'he2,8'h43,8'h86,8'h8b,8'h91,8'ha5,8'hcd,
      8'h1d,8'h3a,8'h74,8'he8,8'h57,8'hae,8'hdb,8'h31,8'h62,8'hc4,8'h0f,8'h1e,8'h3c,8'h78,8'hf0,8'h67,
      8'hce,8'h1b,8'h36,8'h6c,8'hd8,8'h37,8'h6e,8'hdc,8'h3f,8'h7e,8'hfc,8'h7f,8'hfe,8'h7b,8'hf6,8'h6b,
      8'hd6,8'h2b,8'h56,8'hac,8'hdf,8'h39,8'h72,8'he4,8'h4f,8'h9e,8'hbb,8'hf1,8'h65,8'hca,8'h13,8'h26,
      8'h4c,8'h98,8'hb7,8'he9,8'h55,8'haa,8'hd3,8'h21,8'h42,8'h84,8'h8f,8'h99,8'hb5,8'hed,8'h5d,8'hba,
      8'hf3,8'h61,8'hc2,8'h03,8'h06,8'h0c,8'h18,8'h30,8'h60,8'hc0,8'h07,8'h0e,8'h1c,8'h38,8'h70,8'he0,
      8'h47,8'h8e,8'h9b,8'hb1,8'he5,8'h4d,8'h9a,8'hb3,8'he1,8'h45,8'h8a,8'h93,8'ha1,8'hc5,8'h0d,8'h1a,
      8'h34,8'h68,8'hd0,8'h27,8'h4e,8'h9c,8'hbf,8'hf9,8'h75,8'hea,8'h53,8'ha6,8'hcb,8'h11,8'h22,8'h44,
      8'h88,8'h97,8'ha9,8'hd5,8'h2d,8'h5a,8'hb4,8'hef,8'h59,8'hb2,8'he3,8'h41,8'h82,8'h83,8'h81,8'h85,
      8'h8d,8'h9d,8'hbd,8'hfd,8'h7d,8'hfa,8'h73,8'he6,8'h4b,8'h96,8'hab,8'hd1,8'h25,8'h4a,8'h94,8'haf,
      8'hd9,8'h35,8'h6a,8'hd4,8'h2f,8'h5e,8'hbc,8'hff,8'h79,8'hf2,8'h63,8'hc6,8'h0b,8'h16,8'h2c,8'h58,
      8'hb0,8'he7,8'h49,8'h92,8'ha3,8'hc1,8'h05,8'h0a,8'h14,8'h28,8'h50,8'ha0,8'hc7,8'h09,8'h12,8'h24,
      8'h48,8'h90,8'ha7,8'hc9,8'h15,8'h2a,8'h54,8'ha8,8'hd7,8'h29,8'h52,8'ha4,8'hcf,8'h19,8'h32,8'h64,
      8'hc8,8'h17,8'h2e,8'h5c,8'hb8,8'hf7,8'h69,8'hd2,8'h23,8'h46,8'h8c,8'h9f,8'hb9,8'hf5,8'h6d,8'hda,
      8'h33,8'h66,8'hcc,8'h1f,8'h3e,8'h7c,8'hf8,8'h77,8'hee,8'h5b,8'hb6,8'heb,8'h51,8'ha2,8'hc3,8'h00
   };

   // entry 0 has no logarithm and holds 255
   localparam byte_type GF_LOG [256] = '{
      8'd255,8'd0,8'd1,8'd99,8'd2,8'd198,8'd100,8'd106,8'd3,8'd205,8'd199,8'd188,8'd101,8'd126,8'd107,8'd42,
      8'd4,8'd141,8'd206,8'd78,8'd200,8'd212,8'd189,8'd225,8'd102,8'd221,8'd127,8'd49,8'd108,8'd32,8'd43,8'd243,
      8'd5,8'd87,8'd142,8'd232,8'd207,8'd172,8'd79,8'd131,8'd201,8'd217,8'd213,8'd65,8'd190,8'd148,8'd226,8'd180,
      8'd103,8'd39,8'd222,8'd240,8'd128,8'd177,8'd50,8'd53,8'd109,8'd69,8'd33,8'd18,8'd44,8'd13,8'd244,8'd56,
      8'd6,8'd155,8'd88,8'd26,8'd143,8'd121,8'd233,8'd112,8'd208,8'd194,8'd173,8'd168,8'd80,8'd117,8'd132,8'd72,
      8'd202,8'd252,8'd218,8'd138,8'd214,8'd84,8'd66,8'd36,8'd191,8'd152,8'd149,8'd249,8'd227,8'd94,8'd181,8'd21,
      8'd104,8'd97,8'd40,8'd186,8'd223,8'd76,8'd241,8'd47,8'd129,8'd230,8'd178,8'd63,8'd51,8'd238,8'd54,8'd16,
      8'd110,8'd24,8'd70,8'd166,8'd34,8'd136,8'd19,8'd247,8'd45,8'd184,8'd14,8'd61,8'd245,8'd164,8'd57,8'd59,
      8'd7,8'd158,8'd156,8'd157,8'd89,8'd159,8'd27,8'd8,8'd144,8'd9,8'd122,8'd28,8'd234,8'd160,8'd113,8'd90,
      8'd209,8'd29,8'd195,8'd123,8'd174,8'd10,8'd169,8'd145,8'd81,8'd91,8'd118,8'd114,8'd133,8'd161,8'd73,8'd235,
      8'd203,8'd124,8'd253,8'd196,8'd219,8'd30,8'd139,8'd210,8'd215,8'd146,8'd85,8'd170,8'd67,8'd11,8'd37,8'd175,
      8'd192,8'd115,8'd153,8'd119,8'd150,8'd92,8'd250,8'd82,8'd228,8'd236,8'd95,8'd74,8'd182,8'd162,8'd22,8'd134,
      8'd105,8'd197,8'd98,8'd254,8'd41,8'd125,8'd187,8'd204,8'd224,8'd211,8'd77,8'd140,8'd242,8'd31,8'd48,8'd220,
      8'd130,8'd171,8'd231,8'd86,8'd179,8'd147,8'd64,8'd216,8'd52,8'd176,8'd239,8'd38,8'd55,8'd12,8'd17,8'd68,
      8'd111,8'd120,8'd25,8'd154,8'd71,8'd116,8'd167,8'd193,8'd35,8'd83,8'd137,8'd251,8'd20,8'd93,8'd248,8'd151,
      8'd46,8'd75,8'd185,8'd96,8'd15,8'd237,8'd62,8'd229,8'd246,8'd135,8'd165,8'd23,8'd58,8'd163,8'd60,8'd183
   };

   // generator coefficients as logarithms, constant term first, monic term dropped
   localparam byte_type GEN_T16 [32] = '{
      8'd0,8'd249,8'd59,8'd66,8'd4,8'd43,8'd126,8'd251,8'd97,8'd30,8'd3,8'd213,8'd50,8'd66,8'd170,8'd5,
      8'd24,8'd5,8'd170,8'd66,8'd50,8'd213,8'd3,8'd30,8'd97,8'd251,8'd126,8'd43,8'd4,8'd66,8'd59,8'd249
   };

   localparam byte_type GEN_T8 [16] = '{
      8'd122,8'd240,8'd18,8'd180,8'd199,8'd181,8'd221,8'd49,
      8'd234,8'd225,8'd63,8'd199,8'd138,8'd40,8'd54,8'd197
   };

   // antilog of a sum of two logs, reduced mod 255
   function automatic byte_type exp_of_sum(input byte_type a, input byte_type b);
      logic [ByteWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 9'd255) begin
         s = s - 9'd255;
      end
      return GF_EXP[s[ByteWidth-1:0]];
   endfunction

endpackage

/* rtl/rsce_parity_cell.sv */
// one cell of the parity shift register: stores a byte and adds in the
// feedback times its generator coefficient; uses rsce_pkg
module rsce_parity_cell #(
   parameter int unsigned CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsce_pkg::cell_ctrl_type ctrl,
   input  rsce_pkg::byte_type     neighbor_in,
   output rsce_pkg::byte_type     parity_out,
   output rsce_pkg::byte_type     parity_upd
);
   import rsce_pkg::*;

   localparam logic [4:0] Idx = 5'(CELL_INDEX);

   byte_type parity_ff;
   byte_type parity_in;
   byte_type coef;
   byte_type term;
   logic     active;

   // cell i uses coefficient n-1-i, which is the bitwise complement of i
   assign coef   = ctrl.mode32 ? GEN_T16[~Idx] : GEN_T8[~Idx[3:0]];
   assign active = ctrl.mode32 || !Idx[4];
   assign term   = ctrl.live ? exp_of_sum(ctrl.fb_log, coef) : '0;

   assign parity_upd = active ? (neighbor_in ^ term) : '0;

   always_comb begin
      priority if (ctrl.clear) begin
         parity_in = '0;
      end else if (ctrl.shift_en) begin
         parity_in = parity_upd;
      end else begin
         parity_in = parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
      end else begin
         parity_ff <= parity_in;
      end
   end

   assign parity_out = parity_ff;

endmodule

/* rtl/rsce_out_buffer.sv */
// output shift chain: holds one message's parity words and sends them out
// first word first; uses rsce_pkg
module rsce_out_buffer #(
   parameter int unsigned MAX_PARITY = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rsce_pkg::load_ctrl_type load,
   input  rsce_pkg::byte_type      load_data [MAX_PARITY],
   output logic                    can_load,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [7:0]              rsp_tdata,   // [7:0] parity_byte
   output logic                    rsp_tlast,
   output logic                    rsp_tuser    // [0] length_error
);
   import rsce_pkg::*;

   byte_type              data_ff [MAX_PARITY];
   byte_type              data_in [MAX_PARITY];
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  error_ff;
   logic                  error_in;
   logic                  pop;

   assign pop      = rsp_tvalid && rsp_tready;
   assign can_load = (count_ff == '0) || (count_ff == ONE_WORD && rsp_tready);

   always_comb begin
      for (int i = 0; i < MAX_PARITY; i++) begin
         if (load.valid) begin
            data_in[i] = load.error ? '0 : load_data[i];
         end else if (pop) begin
            data_in[i] = (i + 1 < MAX_PARITY) ? data_ff[(i + 1) % MAX_PARITY] : '0;
         end else begin
            data_in[i] = data_ff[i];
         end
      end
   end

   always_comb begin
      priority if (load.valid) begin
         count_in = load.count;
         error_in = load.error;
      end else if (pop) begin
         count_in = count_ff - ONE_WORD;
         error_in = error_ff;
      end else begin
         count_in = count_ff;
         error_in = error_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PARITY; i++) begin
         data_ff[i] <= data_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         error_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         error_ff <= error_in;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = data_ff[0];
   assign rsp_tlast  = (count_ff == ONE_WORD);
   assign rsp_tuser  = error_ff;

endmodule

/* rtl/reed_solomon_ccsds_encoder.sv */
// reed-solomon (255,223)/(255,239) ccsds encoder top level
// latency: first parity word is valid the cycle after the last message word
// throughput: one message word per clock through the parity cells; a last word
// waits while the previous message's 16 or 32 parity words or error word drain
// reset: parity cells, counters and output buffer clear, roots_mode returns to 1
module reed_solomon_ccsds_encoder #(
   parameter int unsigned MAX_PARITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] parity_byte
   output logic        rsp_tlast,
   output logic        rsp_tuser,   // [0] length_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rsce_pkg::*;

   logic                  roots_mode_ff;
   logic                  roots_mode_in;
   byte_type              count_ff;
   byte_type              count_in;
   logic                  too_long_ff;
   logic                  too_long_in;

   logic                  mode32;
   logic [CountWidth-1:0] n_parity;
   byte_type              limit;
   byte_type              count_next;
   logic                  too_long_next;
   logic                  accept;
   logic                  msg_end;
   logic                  cfg_write;
   logic                  can_load;
   byte_type              fb_val;

   cell_ctrl_type         cell_ctrl;
   load_ctrl_type         load;
   byte_type              parity_q   [MAX_PARITY];
   byte_type              parity_upd [MAX_PARITY];
   byte_type              neighbor   [MAX_PARITY];

   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_ROOTS_MODE);
   assign csr_prdata = (csr_paddr[2] == CSR_ROOTS_MODE) ?
                       {{(CsrDataWidth-1){1'b0}}, roots_mode_ff} : '0;
   assign roots_mode_in = cfg_write ? csr_pwdata[0] : roots_mode_ff;

   assign mode32   = roots_mode_ff && (MAX_PARITY >= 32);
   assign n_parity = mode32 ? PARITY_T16 : PARITY_T8;
   assign limit    = MAX_COUNT - {2'b00, n_parity};

   assign req_tready = can_load || !req_tlast;
   assign accept     = req_tvalid && req_tready;
   assign msg_end    = accept && req_tlast;

   assign count_next    = (count_ff == MAX_COUNT) ? MAX_COUNT : count_ff + 8'd1;
   assign too_long_next = too_long_ff || (count_next > limit);

   // feedback from the incoming word and the first parity cell
   assign fb_val = req_tdata ^ parity_q[0];

   assign cell_ctrl.clear    = cfg_write || msg_end;
   assign cell_ctrl.shift_en = accept && !too_long_next;
   assign cell_ctrl.live     = (fb_val != '0);
   assign cell_ctrl.mode32   = mode32;
   assign cell_ctrl.fb_log   = cell_ctrl.live ? GF_LOG[fb_val] : NO_LOG;

   always_comb begin
      priority if (cfg_write || msg_end) begin
         count_in    = '0;
         too_long_in = 1'b0;
      end else if (accept) begin
         count_in    = count_next;
         too_long_in = too_long_next;
      end else begin
         count_in    = count_ff;
         too_long_in = too_long_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roots_mode_ff <= 1'b1;
         count_ff      <= '0;
         too_long_ff   <= 1'b0;
      end else begin
         roots_mode_ff <= roots_mode_in;
         count_ff      <= count_in;
         too_long_ff   <= too_long_in;
      end
   end

   for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
      // the last active cell shifts in zero
      if (i == MAX_PARITY - 1) begin : g_end
         assign neighbor[i] = '0;
      end else if (i == 15) begin : g_mid
         assign neighbor[i] = mode32 ? parity_q[i + 1] : '0;
      end else begin : g_link
         assign neighbor[i] = parity_q[i + 1];
      end

      rsce_parity_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .neighbor_in (neighbor[i]),
         .parity_out  (parity_q[i]),
         .parity_upd  (parity_upd[i])
      );
   end

   assign load.valid = msg_end;
   assign load.error = too_long_next;
   assign load.count = too_long_next ? ONE_WORD : n_parity;

   rsce_out_buffer #(
      .MAX_PARITY (MAX_PARITY)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_data  (parity_upd),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   a_error_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("length error word not marked last");

   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      msg_end |=> rsp_tvalid && count_ff == '0 && !too_long_ff)
      else $error("message end did not load output or clear state");

   a_cfg_clears: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> parity_q[0] == '0 && count_ff == '0 && !too_long_ff)
      else $error("config write did not abort message");

   a_too_long_holds: assert property (@(posedge clock) disable iff (reset)
      too_long_ff && !msg_end && !cfg_write |=> $stable(parity_q[0]))
      else $error("parity updated after length overflow");

endmodule

/* tb/reed_solomon_ccsds_encoder_tb.sv */
// self-checking testbench for the ccsds reed-solomon parity encoder
// a scoreboard class predicts the parity words; depends on rsce_pkg and the encoder rtl
`timescale 1ns / 100ps

module reed_solomon_ccsds_encoder_tb;
   import rsce_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 2000000;
   localparam int unsigned PHASE_WORDS   = 40;
   localparam int unsigned SETTLE_CYCLES = 4;
   localparam logic [2:0]  ROOTS_MODE_ADDR = {CSR_ROOTS_MODE, 2'b00};
   localparam logic [2:0]  SPARE_ADDR      = {~CSR_ROOTS_MODE, 2'b00};

   // generator coefficients as logs, constant term first, monic term dropped
   localparam byte_type GEN32_LOG [32] = '{
      8'd0, 8'd249, 8'd59, 8'd66, 8'd4, 8'd43, 8'd126, 8'd251,
      8'd97, 8'd30, 8'd3, 8'd213, 8'd50, 8'd66, 8'd170, 8'd5,
      8'd24, 8'd5, 8'd170, 8'd66, 8'd50, 8'd213, 8'd3, 8'd30,
      8'd97, 8'd251, 8'd126, 8'd43, 8'd4, 8'd66, 8'd59, 8'd249
   };
   localparam byte_type GEN16_LOG [16] = '{
      8'd122, 8'd240, 8'd18, 8'd180, 8'd199, 8'd181, 8'd221, 8'd49,
      8'd234, 8'd225, 8'd63, 8'd199, 8'd138, 8'd40, 8'd54, 8'd197
   };

   typedef struct packed {
      byte_type parity;
      logic     last;
      logic     length_error;
   } parity_word_type;

   class parity_scoreboard;
      byte_type        exp_tab [256];
      byte_type        log_tab [256];
      byte_type        stage [32];
      int unsigned     byte_count;
      bit              too_long;
      bit              mode32;
      parity_word_type parity_due [$];
      int unsigned     mismatches;
      int unsigned     words_checked;
      int unsigned     messages;
      int unsigned     long_messages;

      function new();
         logic [8:0] x;
         x = 9'd1;
         for (int i = 0; i < 255; i++) begin
            exp_tab[i] = x[7:0];
            log_tab[x[7:0]] = byte_type'(i);
            x = x << 1;
            if (x[8]) begin
               x = x ^ 9'h187;
            end
         end
         exp_tab[255] = 8'h00;
         log_tab[0] = 8'd255;
         mode32 = 1'b1;
         mismatches = 0;
         words_checked = 0;
         messages = 0;
         long_messages = 0;
         clear_message();
      endfunction

      function void clear_message();
         foreach (stage[i]) stage[i] = 8'h00;
         byte_count = 0;
         too_long = 1'b0;
      endfunction

      function int unsigned parity_count();
         return mode32 ? 32 : 16;
      endfunction

      function byte_type gf_mul(int unsigned a, int unsigned b);
         int unsigned s;
         s = a + b;
         if (s >= 255) begin
            s = s - 255;
         end
         return exp_tab[s];
      endfunction

      function byte_type gen_log(int unsigned k);
         return mode32 ? GEN32_LOG[k] : GEN16_LOG[k];
      endfunction

      function void absorb_byte(byte_type d);
         byte_type    next_stage [32];
         int unsigned n;
         int unsigned fb;
         bit          live;
         n = parity_count();
         fb = log_tab[d ^ stage[0]];
         live = (fb != 255);
         next_stage = stage;
         for (int unsigned j = 1; j < n; j++) begin
            next_stage[j-1] = stage[j] ^ (live ? gf_mul(fb, gen_log(n - j)) : 8'h00);
         end
         next_stage[n-1] = live ? gf_mul(fb, gen_log(0)) : 8'h00;
         stage = next_stage;
      endfunction

      function void set_mode(logic m);
         mode32 = m;
         clear_message();
      endfunction

      function byte_type first_stage();
         return stage[0];
      endfunction

      function void note_word(byte_type d, logic last);
         int unsigned     n;
         parity_word_type w;
         n = parity_count();
         if (byte_count < 255) begin
            byte_count++;
         end
         if (byte_count > 255 - n) begin
            too_long = 1'b1;
         end
         if (!too_long) begin
            absorb_byte(d);
         end
         if (!last) begin
            return;
         end
         messages++;
         if (too_long) begin
            long_messages++;
            w.parity = 8'h00;
            w.last = 1'b1;
            w.length_error = 1'b1;
            parity_due.push_back(w);
         end else begin
            for (int unsigned k = 0; k < n; k++) begin
               w.parity = stage[k];
               w.last = (k == n - 1);
               w.length_error = 1'b0;
               parity_due.push_back(w);
            end
         end
         clear_message();
      endfunction

      function void check_word(parity_word_type got);
         parity_word_type want;
         if (parity_due.size() == 0) begin
            $display("%0t: unexpected parity word: byte %h last %b error %b",
                     $time, got.parity, got.last, got.length_error);
            mismatches++;
            return;
         end
         want = parity_due.pop_front();
         words_checked++;
         if (got.parity !== want.parity || got.last !== want.last ||
             got.length_error !== want.length_error) begin
            $display("%0t: parity word mismatch: expected byte %h last %b error %b,",
                     $time, want.parity, want.last, want.length_error);
            $display("%0t:    got byte %h last %b error %b",
                     $time, got.parity, got.last, got.length_error);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;           // [7:0] parity_byte
   logic        rsp_tlast;
   logic        rsp_tuser;           // [0] length_error
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   parity_scoreboard sb;
   bit               no_idle = 1'b0;
   int unsigned      cycles = 0;
   int unsigned      words_sent = 0;

   reed_solomon_ccsds_encoder dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_delay();
      return no_idle ? 0 : $urandom_range(0, 17);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_word(parity_word_type'({rsp_tdata, rsp_tlast, rsp_tuser}));
      end
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: random stall before taking each word
   initial begin
      int unsigned stall;
      @(negedge reset);
      forever begin
         stall = draw_delay();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic send_word(input byte_type d, input logic last);
      int unsigned gap;
      gap = draw_delay();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      sb.note_word(d, last);
      words_sent++;
   endtask

   task automatic send_message(input int unsigned len);
      byte_type    d;
      int unsigned pick;
      for (int unsigned i = 0; i < len; i++) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) begin
            d = sb.first_stage();   // cancels the feedback term
         end else if (pick == 1) begin
            d = 8'h00;
         end else if (pick == 2) begin
            d = 8'hff;
         end else begin
            d = byte_type'($urandom);
         end
         send_word(d, i == len - 1);
      end
   endtask

   // settle must be at least one so valid is never lowered and raised in one step
   task automatic drain_results(input int unsigned settle);
      req_tvalid <= 1'b0;
      while (sb.parity_due.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (wr && addr[2] == CSR_ROOTS_MODE) begin
         sb.set_mode(wdata[0]);
      end
      @(posedge clock);
   endtask

   task automatic check_roots_mode(input logic want);
      logic [31:0] rd;
      csr_access(1'b0, ROOTS_MODE_ADDR, 32'd0, rd);
      if (rd[0] !== want) begin
         $display("%0t: roots_mode readback: expected %b, got %b", $time, want, rd[0]);
         sb.mismatches++;
      end
   endtask

   task automatic set_roots_mode(input logic mode, input logic [31:0] wdata);
      logic [31:0] rd;
      logic [31:0] v;
      drain_results(SETTLE_CYCLES);
      v = wdata;
      v[0] = mode;
      csr_access(1'b1, ROOTS_MODE_ADDR, v, rd);
      check_roots_mode(mode);
   endtask

   initial begin
      logic [31:0] rd;
      logic        phase_mode [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
      int unsigned long_len [6]   = '{224, 0, 0, 0, 0, 0};
      int unsigned phase_start;
      int unsigned len;

      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 32 parity words after reset
      check_roots_mode(1'b1);
      send_word(8'h00, 1'b1);
      send_word(8'hff, 1'b1);
      send_word(8'h80, 1'b0);
      send_word(sb.first_stage(), 1'b0);
      send_word(8'h01, 1'b0);
      send_word(8'h7f, 1'b1);

      // directed: 16 parity words, then a write to an unused index
      set_roots_mode(1'b0, 32'hffff_fffe);
      send_word(8'hff, 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'h00, 1'b0);
      send_word(8'h55, 1'b0);
      send_word(8'haa, 1'b1);
      drain_results(SETTLE_CYCLES);
      csr_access(1'b1, SPARE_ADDR, 32'hffff_ffff, rd);
      check_roots_mode(1'b0);
      send_word(8'hc3, 1'b0);
      send_word(sb.first_stage(), 1'b1);

      // random phases; the first opens with a message just past the length limit
      for (int ph = 0; ph < 6; ph++) begin
         set_roots_mode(phase_mode[ph], (ph == 3) ? 32'h0000_0001 : $urandom);
         no_idle = 1'b0;
         if (long_len[ph] != 0) begin
            send_message(long_len[ph]);
         end
         phase_start = words_sent;
         while (words_sent - phase_start < PHASE_WORDS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 24);
            send_message(len);
            if ($urandom_range(0, 9) == 0) begin
               drain_results(1);
            end
         end
      end

      drain_results(8);
      $display("sent %0d message words in %0d messages (%0d over length), both parity sizes",
               words_sent, sb.messages, sb.long_messages);
      $display("checked %0d parity words in %0d cycles", sb.words_checked, cycles);
      if (sb.mismatches == 0 && sb.parity_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

/* reed_solomon_ccsds_encoder.f */
rtl/rsce_pkg.sv
rtl/rsce_parity_cell.sv
rtl/rsce_out_buffer.sv
rtl/reed_solomon_ccsds_encoder.sv
tb/reed_solomon_ccsds_encoder_tb.sv
